### design/uup_pkg.sv
// Shared types, constants and helpers for the URL percent-unescape block.
package uup_pkg;

  localparam int BYTE_W          = 8;
  localparam int OUT_LEN_W       = 17;
  localparam int CFG_DATA_W      = 17;
  localparam int CFG_IDX_W       = 2;
  localparam int DEFAULT_MAX_LEN = 65536;
  localparam int QUEUE_DEPTH     = 2;
  localparam int RUN_CNT_W       = 2;
  localparam int RUN_MAX         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IN_PLACE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_QUERY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UTF8       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_CAP   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_QUERY   = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_PCT      = 3'd1,
    PH_PCT_HI   = 3'd2,
    PH_VERBATIM = 3'd3,
    PH_STOPPED  = 3'd4
  } phase_e;

  // One request for the back end: up to three results, the last of which
  // is the status when eos is set.
  typedef struct packed {
    logic [RUN_CNT_W-1:0]            cnt;
    logic [RUN_MAX-1:0][BYTE_W-1:0]  data;
    logic                            eos;
    logic [1:0]                      code;
    logic [OUT_LEN_W-1:0]            len;
  } cmd_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

### design/uup_front.sv
// Front end: configuration, escape decoding state and request classification.
module uup_front #(
  parameter int MAX_LEN = uup_pkg::DEFAULT_MAX_LEN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uup_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [uup_pkg::BYTE_W-1:0]      src_byte_i,
  input  logic                            end_of_string_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output uup_pkg::cmd_t                   q_cmd_o
);

  localparam int CNT_W = $clog2(MAX_LEN);
  localparam int SUM_W = CNT_W + 1;
  localparam int LEN_W = (CNT_W + 1 > uup_pkg::OUT_LEN_W) ? CNT_W + 1 : uup_pkg::OUT_LEN_W;
  localparam logic [SUM_W-1:0] SAT_MAX = SUM_W'(MAX_LEN - 1);

  logic                             in_place_q;
  logic                             stop_query_q;
  logic                             utf8_q;
  logic [uup_pkg::CFG_DATA_W-1:0]   cap_q;

  uup_pkg::phase_e                  phase_q, phase_d;
  logic [uup_pkg::BYTE_W-1:0]       held_q, held_d;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic                             zero_q, zero_d;

  logic                             accept;
  uup_pkg::cmd_t                    cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (cmd.cnt != '0);
  assign q_cmd_o    = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_place_q   <= 1'b0;
      stop_query_q <= 1'b0;
      utf8_q       <= 1'b0;
      cap_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uup_pkg::REG_IN_PLACE:   in_place_q   <= cfg_wdata_i[0];
        uup_pkg::REG_STOP_QUERY: stop_query_q <= cfg_wdata_i[0];
        uup_pkg::REG_UTF8:       utf8_q       <= cfg_wdata_i[0];
        uup_pkg::REG_DEST_CAP:   cap_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uup_pkg::PH_NORMAL;
      held_q  <= '0;
      count_q <= '0;
      zero_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      count_q <= count_d;
      zero_q  <= zero_d;
    end
  end

  always_comb begin
    logic [4:0]                  hc;
    logic [4:0]                  hh;
    logic [uup_pkg::BYTE_W-1:0]  c;
    logic [uup_pkg::BYTE_W-1:0]  v;
    logic [uup_pkg::RUN_CNT_W-1:0] nb;
    logic                        plain;
    logic [SUM_W-1:0]            sum;
    logic [CNT_W-1:0]            cnt_f;
    logic [LEN_W-1:0]            len_w;

    c       = src_byte_i;
    hc      = uup_pkg::hex_value(src_byte_i);
    hh      = uup_pkg::hex_value(held_q);
    v       = {hh[3:0], hc[3:0]};
    nb      = '0;
    plain   = 1'b0;
    len_w   = '0;
    phase_d = phase_q;
    held_d  = held_q;
    zero_d  = zero_q;
    cmd     = '0;

    if (end_of_string_i) begin
      unique case (phase_q)
        uup_pkg::PH_PCT: begin
          cmd.data[0] = uup_pkg::CH_PERCENT;
          nb          = 2'd1;
        end
        uup_pkg::PH_PCT_HI: begin
          cmd.data[0] = uup_pkg::CH_PERCENT;
          cmd.data[1] = held_q;
          nb          = 2'd2;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_q)
        uup_pkg::PH_STOPPED: ;
        uup_pkg::PH_VERBATIM: begin
          cmd.data[0] = c;
          nb          = 2'd1;
        end
        uup_pkg::PH_PCT: begin
          if (hc[4]) begin
            held_d  = c;
            phase_d = uup_pkg::PH_PCT_HI;
          end else begin
            cmd.data[0] = uup_pkg::CH_PERCENT;
            nb          = 2'd1;
            plain       = 1'b1;
          end
        end
        uup_pkg::PH_PCT_HI: begin
          if (hc[4] && hh[4]) begin
            if (v == '0) begin
              phase_d = uup_pkg::PH_STOPPED;
              zero_d  = 1'b1;
            end else begin
              phase_d     = uup_pkg::PH_NORMAL;
              cmd.data[0] = v;
              nb          = 2'd1;
            end
          end else begin
            cmd.data[0] = uup_pkg::CH_PERCENT;
            cmd.data[1] = held_q;
            nb          = 2'd2;
            plain       = 1'b1;
          end
        end
        default: plain = 1'b1;
      endcase
      if (plain) begin
        priority if (stop_query_q && (c == uup_pkg::CH_QUERY || c == uup_pkg::CH_HASH)) begin
          phase_d      = uup_pkg::PH_VERBATIM;
          cmd.data[nb] = c;
          nb           = nb + 2'd1;
        end else if (c == uup_pkg::CH_PERCENT) begin
          phase_d = uup_pkg::PH_PCT;
        end else begin
          phase_d      = uup_pkg::PH_NORMAL;
          cmd.data[nb] = c;
          nb           = nb + 2'd1;
        end
      end
    end

    sum   = SUM_W'(count_q) + SUM_W'(nb);
    cnt_f = (sum > SAT_MAX) ? CNT_W'(SAT_MAX) : CNT_W'(sum);
    count_d = cnt_f;
    cmd.cnt = nb;

    if (end_of_string_i) begin
      priority if (in_place_q) begin
        cmd.code = zero_q ? uup_pkg::ST_INVALID : uup_pkg::ST_OK;
        len_w    = zero_q ? '0 : LEN_W'(cnt_f);
      end else if (cap_q == '0 || utf8_q) begin
        cmd.code = uup_pkg::ST_INVALID;
      end else if (LEN_W'(cap_q) <= LEN_W'(cnt_f)) begin
        cmd.code = uup_pkg::ST_TOO_SMALL;
        len_w    = LEN_W'(cnt_f) + LEN_W'(1);
      end else begin
        cmd.code = uup_pkg::ST_OK;
        len_w    = LEN_W'(cnt_f);
      end
      cmd.len = len_w[uup_pkg::OUT_LEN_W-1:0];
      cmd.eos = 1'b1;
      cmd.cnt = nb + 2'd1;
      phase_d = uup_pkg::PH_NORMAL;
      held_d  = '0;
      count_d = '0;
      zero_d  = 1'b0;
    end
  end

endmodule

### design/uup_queue.sv
// Short request queue between the front and back ends.
module uup_queue #(
  parameter int DEPTH = uup_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uup_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output uup_pkg::cmd_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uup_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

endmodule

### design/uup_back.sv
// Back end: expands queued requests into result items behind an output register.
module uup_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  uup_pkg::cmd_t                   q_head_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [uup_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                            is_status_o,
  output logic [1:0]                      status_code_o,
  output logic [uup_pkg::OUT_LEN_W-1:0]   result_length_o,
  output logic                            last_of_run_o
);

  logic [uup_pkg::RUN_CNT_W-1:0]    idx_q, idx_d;
  logic                             valid_q;
  logic [uup_pkg::BYTE_W-1:0]       byte_q, byte_d;
  logic                             status_q, status_d;
  logic [1:0]                       code_q, code_d;
  logic [uup_pkg::OUT_LEN_W-1:0]    len_q, len_d;
  logic                             last_q, last_d;
  logic                             load;
  logic                             take;

  assign load            = !valid_q || out_ready_i;
  assign take            = load && !q_empty_i;
  assign q_pop_o         = take && last_d;
  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign is_status_o     = status_q;
  assign status_code_o   = code_q;
  assign result_length_o = len_q;
  assign last_of_run_o   = last_q;

  always_comb begin
    logic [uup_pkg::BYTE_W-1:0] b;
    unique case (idx_q)
      2'd0:    b = q_head_i.data[0];
      2'd1:    b = q_head_i.data[1];
      default: b = q_head_i.data[2];
    endcase
    last_d   = (idx_q == q_head_i.cnt - 2'd1);
    status_d = last_d && q_head_i.eos;
    byte_d   = status_d ? '0 : b;
    code_d   = status_d ? q_head_i.code : uup_pkg::ST_OK;
    len_d    = status_d ? q_head_i.len : '0;
    idx_d    = last_d ? '0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !q_empty_i;
      end
      if (take) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      code_q   <= code_d;
      len_q    <= len_d;
      last_q   <= last_d;
    end
  end

endmodule

### design/url_percent_unescape.sv
// URL percent-unescape top level: front end, request queue and back end.
// Takes one source byte per cycle and gives one result item per cycle when the
// output is not stalled, via the request queue and the output register. A
// source byte yields zero to three results (an incomplete escape flushes '%'
// and the held digit before the byte itself; the end marker flushes and adds
// the status); the back end drains one result a cycle when not stalled, so a
// byte that yields two or three results can hold the input once the two-entry
// request queue fills. The user must write configuration through the plain
// write port while the block is idle; this is not enforced. The status item
// closes each string; commit the data bytes only when its code is ok.
module url_percent_unescape #(
  parameter int MAX_LEN = uup_pkg::DEFAULT_MAX_LEN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [uup_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [uup_pkg::BYTE_W-1:0]      src_byte_i,
  input  logic                            end_of_string_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [uup_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                            is_status_o,
  output logic [1:0]                      status_code_o,
  output logic [uup_pkg::OUT_LEN_W-1:0]   result_length_o,
  output logic                            last_of_run_o
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  uup_pkg::cmd_t q_cmd;
  uup_pkg::cmd_t q_head;

  uup_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .src_byte_i      (src_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd)
  );

  uup_queue #(
    .DEPTH (uup_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  uup_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_status_o     (is_status_o),
    .status_code_o   (status_code_o),
    .result_length_o (result_length_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
